>>> hdl/trilinear_constraint_force_differential_core_defines.svh
// Assertion macros shared by the trilinear constraint force differential RTL.
// Depends on nothing; included by the files that carry concurrent assertions.
`ifndef TRILINEAR_CONSTRAINT_FORCE_DIFFERENTIAL_CORE_DEFINES_SVH
`define TRILINEAR_CONSTRAINT_FORCE_DIFFERENTIAL_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCFD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCFD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/tcfd_pkg.sv
// Package for the trilinear constraint force differential core: widths,
// constants, sequencer states, operand selects and the control struct. No dependencies.
`default_nettype none

package tcfd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned WGT_W  = 16;
    localparam int unsigned MUL_W  = 33;
    localparam int unsigned PROD_W = 2 * MUL_W;
    localparam int unsigned ACC_W  = 52;
    localparam int unsigned CRN_W  = 3;

    localparam logic [WGT_W-1:0] ONE_Q15 = 16'h8000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_W_A,
        ST_W_B,
        ST_ACC_X,
        ST_ACC_Y,
        ST_ACC_Z,
        ST_ACC_END,
        ST_SAT,
        ST_E_WA,
        ST_E_WB,
        ST_E_K,
        ST_E_FX,
        ST_E_FY,
        ST_E_FZ,
        ST_E_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_F01,
        OP_PF2,
        OP_WDX,
        OP_WDY,
        OP_WDZ,
        OP_SW,
        OP_KSX,
        OP_KSY,
        OP_KSZ
    } opsel_t;

    typedef struct packed {
        logic             take;
        logic             mul_en;
        opsel_t           opsel;
        logic [2:0]       acc_en;
        logic             acc_clr;
        logic             w_load;
        logic             sum_load;
        logic             k_load;
        logic             fx_load;
        logic             fy_load;
        logic             out_load;
        logic [CRN_W-1:0] corner;
    } ctrl_t;

endpackage

`default_nettype wire

>>> hdl/tcfd_in_if.sv
// Input channel of the trilinear constraint force differential core: one corner per request.
// Depends on tcfd_pkg.
`default_nettype none

interface tcfd_in_if;
    import tcfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [WGT_W-1:0]         weight_x;
    logic [WGT_W-1:0]         weight_y;
    logic [WGT_W-1:0]         weight_z;
    logic signed [DATA_W-1:0] stiffness_scale;
    logic signed [DATA_W-1:0] du_x;
    logic signed [DATA_W-1:0] du_y;
    logic signed [DATA_W-1:0] du_z;
    logic signed [DATA_W-1:0] df_x;
    logic signed [DATA_W-1:0] df_y;
    logic signed [DATA_W-1:0] df_z;

    modport source (
        output valid, weight_x, weight_y, weight_z, stiffness_scale,
               du_x, du_y, du_z, df_x, df_y, df_z,
        input  ready
    );

    modport sink (
        input  valid, weight_x, weight_y, weight_z, stiffness_scale,
               du_x, du_y, du_z, df_x, df_y, df_z,
        output ready
    );

endinterface

`default_nettype wire

>>> hdl/tcfd_out_if.sv
// Result channel of the trilinear constraint force differential core: one corner force per request.
// Depends on tcfd_pkg.
`default_nettype none

interface tcfd_out_if;
    import tcfd_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CRN_W-1:0]         corner;
    logic signed [DATA_W-1:0] force_x;
    logic signed [DATA_W-1:0] force_y;
    logic signed [DATA_W-1:0] force_z;
    logic                     last;

    modport source (
        output valid, corner, force_x, force_y, force_z, last,
        input  ready
    );

    modport sink (
        input  valid, corner, force_x, force_y, force_z, last,
        output ready
    );

endinterface

`default_nettype wire

>>> hdl/tcfd_mul.sv
// Shared signed multiplier with a registered product.
// Depends on tcfd_pkg.
`default_nettype none

module tcfd_mul (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [tcfd_pkg::MUL_W-1:0]  a,
    input  wire logic signed [tcfd_pkg::MUL_W-1:0]  b,
    output logic signed [tcfd_pkg::PROD_W-1:0]      prod
);
    import tcfd_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= a * b;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

>>> hdl/tcfd_seq.sv
// Sequencer of the trilinear constraint force differential core: state machine and corner counter.
// Depends on tcfd_pkg and the assertion macro header.
`default_nettype none
`include "trilinear_constraint_force_differential_core_defines.svh"

module tcfd_seq (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire logic          out_free,
    output tcfd_pkg::ctrl_t    ctrl
);
    import tcfd_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CRN_W-1:0]   corner_reg;
    logic [CRN_W-1:0]   corner_next;
    logic               last_corner;

    assign last_corner = (corner_reg == {CRN_W{1'b1}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            corner_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            corner_reg <= corner_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        corner_next = corner_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_valid) state_next = ST_W_A;
            ST_W_A:     state_next = ST_W_B;
            ST_W_B:     state_next = ST_ACC_X;
            ST_ACC_X:   state_next = ST_ACC_Y;
            ST_ACC_Y:   state_next = ST_ACC_Z;
            ST_ACC_Z:   state_next = ST_ACC_END;
            ST_ACC_END:
            begin
                corner_next = corner_reg + CRN_W'(1);
                state_next  = last_corner ? ST_SAT : ST_IDLE;
            end
            ST_SAT:     state_next = ST_E_WA;
            ST_E_WA:    state_next = ST_E_WB;
            ST_E_WB:    state_next = ST_E_K;
            ST_E_K:     state_next = ST_E_FX;
            ST_E_FX:    state_next = ST_E_FY;
            ST_E_FY:    state_next = ST_E_FZ;
            ST_E_FZ:    state_next = ST_E_OUT;
            ST_E_OUT:
            begin
                if (out_free)
                begin
                    corner_next = corner_reg + CRN_W'(1);
                    state_next  = last_corner ? ST_IDLE : ST_E_WA;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl          = '0;
        ctrl.opsel    = OP_F01;
        ctrl.corner   = corner_reg;
        ctrl.acc_clr  = (corner_reg == '0);
        unique case (state_reg) inside
            ST_IDLE:    ctrl.take = 1'b1;
            ST_W_A, ST_E_WA:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.opsel  = OP_F01;
            end
            ST_W_B, ST_E_WB:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.opsel  = OP_PF2;
            end
            ST_ACC_X:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.opsel  = OP_WDX;
                ctrl.w_load = 1'b1;
            end
            ST_ACC_Y:
            begin
                ctrl.mul_en    = 1'b1;
                ctrl.opsel     = OP_WDY;
                ctrl.acc_en[0] = 1'b1;
            end
            ST_ACC_Z:
            begin
                ctrl.mul_en    = 1'b1;
                ctrl.opsel     = OP_WDZ;
                ctrl.acc_en[1] = 1'b1;
            end
            ST_ACC_END: ctrl.acc_en[2] = 1'b1;
            ST_SAT:     ctrl.sum_load = 1'b1;
            ST_E_K:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.opsel  = OP_SW;
            end
            ST_E_FX:
            begin
                ctrl.mul_en = 1'b1;
                ctrl.opsel  = OP_KSX;
                ctrl.k_load = 1'b1;
            end
            ST_E_FY:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.opsel   = OP_KSY;
                ctrl.fx_load = 1'b1;
            end
            ST_E_FZ:
            begin
                ctrl.mul_en  = 1'b1;
                ctrl.opsel   = OP_KSZ;
                ctrl.fy_load = 1'b1;
            end
            ST_E_OUT:   ctrl.out_load = out_free;
            default:    ctrl.take = 1'b0;
        endcase
    end

    // A taken corner keeps the block busy for its whole weight and sum sequence.
    `TCFD_ASSERT_NXT(a_busy_after_take, clk, rst_n, ctrl.take && in_valid, !ctrl.take, "corner request taken twice in a row")
    // The eighth corner of a cell starts the emission phase with the counter back at zero.
    `TCFD_ASSERT_NXT(a_cell_wrap, clk, rst_n, state_reg == ST_ACC_END && last_corner, state_reg == ST_SAT && corner_reg == '0, "cell did not wrap into emission")
    // A result held back by the sink keeps the sequencer parked on the same corner.
    `TCFD_ASSERT_NXT(a_stall_holds, clk, rst_n, state_reg == ST_E_OUT && !out_free, state_reg == ST_E_OUT && $stable(corner_reg), "emission moved on during a stall")

endmodule

`default_nettype wire

>>> hdl/trilinear_constraint_force_differential_core.sv
// Top level of the trilinear constraint force differential core: corner datapath and output register.
// Depends on tcfd_pkg, tcfd_in_if, tcfd_out_if, tcfd_mul and tcfd_seq.
//
//   Channel   Direction  Request carries
//   items     in         one cell corner: weights and scale (used on corner 0), du, df
//   results   out        one updated corner force: corner, force x/y/z, last
//
// Each corner request is accepted in the idle state; then the single shared 33 x 33 multiplier
// forms the trilinear weight (two products) and the three weighted displacements, which are
// added to the sums. After the eighth corner the block rounds and saturates the sums, then
// forms each result (weight, stiffness gain, three axis products).
// The block is not ready while a corner is being worked on or a cell is emitted; it becomes
// ready again as soon as the last result is in the output register, which is freed by the sink.
// Reset clears the sequencer, the corner counter and the output valid flag only.
`default_nettype none

module trilinear_constraint_force_differential_core (
    input  wire logic   clk,
    input  wire logic   rst_n,
    tcfd_in_if.sink     items,
    tcfd_out_if.source  results
);
    import tcfd_pkg::*;

    localparam logic signed [PROD_W-1:0] P_BIAS15 = PROD_W'(16384);
    localparam logic signed [PROD_W-1:0] P_BIAS16 = PROD_W'(32768);
    localparam logic signed [ACC_W-1:0]  A_BIAS15 = ACC_W'(16384);
    localparam logic signed [ACC_W-1:0]  SAT_MAX  = ACC_W'(32'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0]  SAT_MIN  = -ACC_W'(33'sh0_8000_0000);

    // Saturate a wide signed value to the 32-bit Q16.16 range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SAT_MAX)
        begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_MIN)
        begin
            r = 32'sh8000_0000;
        end
        else
        begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

    // Round a sum with 31 fraction bits to Q16.16 and saturate it.
    function automatic logic signed [DATA_W-1:0] sum_to_q16(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] b;
        b = (v + A_BIAS15) >>> 15;
        return sat32(b);
    endfunction

    // Clamp an embedding weight to one.
    function automatic logic [WGT_W-1:0] clamp_w(input logic [WGT_W-1:0] v);
        return (v > ONE_Q15) ? ONE_Q15 : v;
    endfunction

    ctrl_t ctrl;
    logic  in_fire;
    logic  out_free;

    // Latched cell parameters and the current corner's displacement.
    logic [WGT_W-1:0]          wx_reg, wy_reg, wz_reg;
    logic signed [DATA_W-1:0]  scale_reg;
    logic signed [DATA_W-1:0]  dux_reg, duy_reg, duz_reg;
    logic signed [DATA_W-1:0]  hfx_reg [8];
    logic signed [DATA_W-1:0]  hfy_reg [8];
    logic signed [DATA_W-1:0]  hfz_reg [8];

    // Working values.
    logic [WGT_W-1:0]          w_reg;
    logic signed [ACC_W-1:0]   accx_reg, accy_reg, accz_reg;
    logic signed [DATA_W-1:0]  sx_reg, sy_reg, sz_reg;
    logic signed [DATA_W-1:0]  k_reg;
    logic signed [DATA_W-1:0]  fx_reg, fy_reg;

    // Output register.
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [CRN_W-1:0]          out_corner_reg;
    logic signed [DATA_W-1:0]  out_fx_reg, out_fy_reg, out_fz_reg;
    logic                      out_last_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_r15, prod_r16;
    logic [WGT_W-1:0]          w_now;
    logic signed [DATA_W-1:0]  k_now;
    logic signed [ACC_W-1:0]   prod_acc;
    logic signed [ACC_W-1:0]   delta;
    logic [WGT_W-1:0]          fx_w, fy_w, fz_w;
    logic signed [DATA_W-1:0]  force_now;
    logic signed [DATA_W-1:0]  df_sel;

    assign in_fire  = items.valid && ctrl.take;
    assign out_free = !out_valid_reg || results.ready;

    tcfd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (items.valid),
        .out_free (out_free),
        .ctrl     (ctrl)
    );

    tcfd_mul u_mul (
        .clk  (clk),
        .en   (ctrl.mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // Per-axis factor of the corner weight: W when the corner bit is set, one minus W otherwise.
    assign fx_w = ctrl.corner[2] ? wx_reg : ONE_Q15 - wx_reg;
    assign fy_w = ctrl.corner[1] ? wy_reg : ONE_Q15 - wy_reg;
    assign fz_w = ctrl.corner[0] ? wz_reg : ONE_Q15 - wz_reg;

    // Rounded and raw views of the registered product.
    assign prod_r15 = (prod + P_BIAS15) >>> 15;
    assign prod_r16 = (prod + P_BIAS16) >>> 16;
    assign w_now    = prod_r15[WGT_W-1:0];
    assign k_now    = prod_r15[DATA_W-1:0];
    assign prod_acc = prod[ACC_W-1:0];
    assign delta    = prod_r16[ACC_W-1:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (ctrl.opsel)
            OP_F01:
            begin
                mul_a = MUL_W'(fx_w);
                mul_b = MUL_W'(fy_w);
            end
            OP_PF2:
            begin
                mul_a = MUL_W'(w_now);
                mul_b = MUL_W'(fz_w);
            end
            OP_WDX:
            begin
                mul_a = MUL_W'(dux_reg);
                mul_b = MUL_W'(w_now);
            end
            OP_WDY:
            begin
                mul_a = MUL_W'(duy_reg);
                mul_b = MUL_W'(w_reg);
            end
            OP_WDZ:
            begin
                mul_a = MUL_W'(duz_reg);
                mul_b = MUL_W'(w_reg);
            end
            OP_SW:
            begin
                mul_a = MUL_W'(scale_reg);
                mul_b = MUL_W'(w_now);
            end
            OP_KSX:
            begin
                mul_a = MUL_W'(k_now);
                mul_b = MUL_W'(sx_reg);
            end
            OP_KSY:
            begin
                mul_a = MUL_W'(k_reg);
                mul_b = MUL_W'(sy_reg);
            end
            OP_KSZ:
            begin
                mul_a = MUL_W'(k_reg);
                mul_b = MUL_W'(sz_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Corner capture: the weights and scale are taken from corner 0 only, the forces are held
    // per corner until the cell is emitted.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (ctrl.corner == '0)
            begin
                wx_reg    <= clamp_w(items.weight_x);
                wy_reg    <= clamp_w(items.weight_y);
                wz_reg    <= clamp_w(items.weight_z);
                scale_reg <= items.stiffness_scale;
            end
            dux_reg <= items.du_x;
            duy_reg <= items.du_y;
            duz_reg <= items.du_z;
            hfx_reg[ctrl.corner] <= items.df_x;
            hfy_reg[ctrl.corner] <= items.df_y;
            hfz_reg[ctrl.corner] <= items.df_z;
        end
    end

    // Weight, weighted displacement sums and emission working values; the first corner of a cell restarts the sums.
    always_ff @(posedge clk)
    begin
        if (ctrl.w_load)
        begin
            w_reg <= w_now;
        end
        if (ctrl.acc_en[0])
        begin
            accx_reg <= ctrl.acc_clr ? prod_acc : accx_reg + prod_acc;
        end
        if (ctrl.acc_en[1])
        begin
            accy_reg <= ctrl.acc_clr ? prod_acc : accy_reg + prod_acc;
        end
        if (ctrl.acc_en[2])
        begin
            accz_reg <= ctrl.acc_clr ? prod_acc : accz_reg + prod_acc;
        end
        if (ctrl.sum_load)
        begin
            sx_reg <= sum_to_q16(accx_reg);
            sy_reg <= sum_to_q16(accy_reg);
            sz_reg <= sum_to_q16(accz_reg);
        end
        if (ctrl.k_load)
        begin
            k_reg <= k_now;
        end
        if (ctrl.fx_load)
        begin
            fx_reg <= force_now;
        end
        if (ctrl.fy_load)
        begin
            fy_reg <= force_now;
        end
    end

    // The axis whose product is in the multiplier register follows from which result is loading.
    always_comb
    begin
        if (ctrl.fx_load)
        begin
            df_sel = hfx_reg[ctrl.corner];
        end
        else if (ctrl.fy_load)
        begin
            df_sel = hfy_reg[ctrl.corner];
        end
        else
        begin
            df_sel = hfz_reg[ctrl.corner];
        end
    end

    assign force_now = sat32(ACC_W'(df_sel) - delta);

    // Output register: the z force is finished in the cycle it is loaded.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_load)
        begin
            out_corner_reg <= ctrl.corner;
            out_fx_reg     <= fx_reg;
            out_fy_reg     <= fy_reg;
            out_fz_reg     <= force_now;
            out_last_reg   <= (ctrl.corner == {CRN_W{1'b1}});
        end
    end

    assign items.ready     = ctrl.take;
    assign results.valid   = out_valid_reg;
    assign results.corner  = out_corner_reg;
    assign results.force_x = out_fx_reg;
    assign results.force_y = out_fy_reg;
    assign results.force_z = out_fz_reg;
    assign results.last    = out_last_reg;

endmodule

`default_nettype wire
